// ===== design/lcg_pkg.sv =====
`default_nettype none

package lcg_pkg;

  // generator word width, fixed by the 32-bit fields of both channels
  localparam int unsigned WordBits = 32;
  localparam int unsigned CntBits  = $clog2(WordBits);

  localparam logic [WordBits-1:0] LcgMul = 32'd1103515245;
  localparam logic [WordBits-1:0] LcgAdd = 32'd123456789;

  // floor(x / 10) == (x * DivRecip) >> RecipShift for every 32-bit x
  localparam logic [WordBits-1:0] DivRecip   = 32'hCCCCCCCD;
  localparam int unsigned         RecipShift = 35;

  typedef enum logic [1:0] {
    OP_DRAW_INT  = 2'd0,
    OP_DRAW_REAL = 2'd1,
    OP_RESEED    = 2'd2,
    OP_NONE      = 2'd3
  } opcode_e;

  typedef struct packed {
    opcode_e               opcode;
    logic [WordBits-1:0]   range_high;
    logic [WordBits-1:0]   range_low;
  } req_t;

  typedef struct packed {
    logic [WordBits-1:0]   draw_value;
    logic                  span_error;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic mul_en;
    logic mul_recip;
    logic advance;
    logic quot_init;
    logic div_step;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    opcode_e op;
    logic    span_zero;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== design/lcg_dp.sv =====
`default_nettype none

module lcg_dp import lcg_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [WordBits-1:0] cfg_wdata_i,
  input  wire req_t                in_req_i,
  input  wire dp_cmd_t             cmd_i,
  output dp_sts_t                  sts_o,
  output rsp_t                     out_rsp_o
);

  logic [WordBits-1:0]   seed_start_q;
  logic [WordBits-1:0]   seed_q, seed_d;
  opcode_e               op_q;
  logic [WordBits-1:0]   hi_q, lo_q;
  logic [2*WordBits-1:0] mul_q;
  logic [WordBits-1:0]   span_q, span_d;
  logic [WordBits-1:0]   dvd_q;
  logic [WordBits-1:0]   rem_q, rem_d;
  logic [WordBits:0]     shifted;
  logic [WordBits:0]     trial;
  logic [WordBits-1:0]   adv_sum;
  rsp_t                  rsp_d, rsp_q;
  logic [WordBits-1:0]   addend;

  // control state: seed and its start register reset to one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_start_q <= WordBits'(1);
      seed_q       <= WordBits'(1);
    end else begin
      if (cfg_we_i) begin
        seed_start_q <= cfg_wdata_i;
      end
      seed_q <= seed_d;
    end
  end

  // one lcg step: wrap, then fold the all-ones word to zero
  assign adv_sum = mul_q[WordBits-1:0] + LcgAdd;

  always_comb begin
    seed_d = seed_q;
    if (cmd_i.load_in && in_req_i.opcode == OP_RESEED) begin
      seed_d = seed_start_q;
    end else if (cmd_i.advance) begin
      seed_d = (adv_sum == '1) ? '0 : adv_sum;
    end
  end

  assign span_d  = hi_q - lo_q + WordBits'(1);
  assign shifted = {rem_q, dvd_q[WordBits-1]};
  assign trial   = shifted - {1'b0, span_q};

  // restoring remainder step, one dividend bit a cycle
  always_comb begin
    if (shifted >= {1'b0, span_q}) begin
      rem_d = trial[WordBits-1:0];
    end else begin
      rem_d = shifted[WordBits-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q <= in_req_i.opcode;
      hi_q <= in_req_i.range_high;
      lo_q <= in_req_i.range_low;
    end
    if (cmd_i.mul_en) begin
      mul_q <= seed_q * (cmd_i.mul_recip ? DivRecip : LcgMul);
    end
    if (cmd_i.quot_init) begin
      dvd_q  <= WordBits'(mul_q >> RecipShift);
      rem_q  <= '0;
      span_q <= span_d;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[WordBits-2:0], 1'b0};
      rem_q <= rem_d;
    end
    if (cmd_i.out_load) begin
      rsp_q <= rsp_d;
    end
  end

  // zero span returns the quotient unreduced
  assign addend = (span_q == '0) ? dvd_q : rem_q;

  always_comb begin
    rsp_d = '0;
    unique case (op_q)
      OP_DRAW_INT: begin
        rsp_d.draw_value = addend + lo_q;
        rsp_d.span_error = (span_q == '0);
      end
      OP_DRAW_REAL: rsp_d.draw_value = seed_q;
      OP_RESEED:    rsp_d = '0;
      OP_NONE:      rsp_d = '0;
      default:      rsp_d = '0;
    endcase
  end

  assign sts_o.op        = op_q;
  assign sts_o.span_zero = (span_d == '0);
  assign out_rsp_o       = rsp_q;

endmodule

`default_nettype wire

// ===== design/lcg_ctrl.sv =====
`default_nettype none

module lcg_ctrl import lcg_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL1 = 7'b0000010,
    ST_ADV  = 7'b0000100,
    ST_MUL2 = 7'b0001000,
    ST_QUOT = 7'b0010000,
    ST_DIV  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_e;

  state_e              state_q, state_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd_o.mul_en = 1'b1;
        state_d      = (sts_i.op == OP_NONE) ? ST_DONE : ST_ADV;
      end
      ST_ADV: begin
        cmd_o.advance = 1'b1;
        state_d       = (sts_i.op == OP_DRAW_INT) ? ST_MUL2 : ST_DONE;
      end
      ST_MUL2: begin
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_recip = 1'b1;
        state_d         = ST_QUOT;
      end
      ST_QUOT: begin
        cmd_o.quot_init = 1'b1;
        cnt_d           = '0;
        state_d         = sts_i.span_zero ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CntBits'(1);
        if (cnt_q == CntBits'(WordBits - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== design/lcg_random_range_draw.sv =====
// channel   | direction | handshake               | payload
// cfg       | in        | cfg_we_i                | cfg_wdata_i (seed_start)
// request   | in        | in_valid_i / in_ready_o | in_req_i (req_t)
// result    | out       | out_valid_o/out_ready_i | out_rsp_o (rsp_t)
//
// an integer draw runs two multiplier passes, the seed fold, the quotient load,
// 32 remainder steps and the output load; a zero span skips the remainder steps
// fraction draws and reseeds stop after the seed fold, an unused opcode after the
// first multiplier pass; the next request is taken the cycle after the output load
// reset sets the seed and seed_start to one and clears the output valid
// a stalled result only holds the controller in its last state
`default_nettype none

module lcg_random_range_draw import lcg_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [WordBits-1:0] cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire req_t                in_req_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output rsp_t                     out_rsp_o
);

  // command and status between sequencer and datapath
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // sequencer: one-hot state machine, bit counter, output valid
  lcg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  // datapath: seed, shared multiplier, remainder unit, output register
  lcg_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_req_i    (in_req_i),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

`default_nettype wire

// ===== design/lcg_chk.sv =====
`default_nettype none

module lcg_chk import lcg_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire rsp_t out_rsp_o
);

  // no result may be shown while reset is applied
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  // one request at a time: the block is busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while busy");

  // no result appears in the cycle after an accept
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result without latency");

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed");

endmodule

bind lcg_random_range_draw lcg_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);

`default_nettype wire
